>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/ubxe_pkg.sv
// Types and constants of the UBX frame encoder.
package ubxe_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam int BURST_MAX = 8;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);
	localparam int IN_DATA_W = 40;

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	typedef logic [7:0] byte_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Checksum and frame tracking state.
	typedef struct packed {
		byte_t       sum_a;
		byte_t       sum_b;
		logic [15:0] bytes_left;
		logic        in_frame;
	} frame_state_t;

	// Output bytes caused by one input beat, first byte in entry 0.
	typedef struct packed {
		byte_t [BURST_MAX-1:0] bytes;
		cnt_t                  cnt;
		logic                  cks;
	} burst_t;

endpackage

>>> rtl/core/ubx_frame_encoder_unit.sv
// Top level of the UBX frame encoder: input handshake, output burst register.
//
// Slave channel s_*: one beat is a frame start (tuser = 0: class, id and
// payload length) or one payload byte (tuser = 1). Master channel m_*: one
// encoded byte per beat; tlast marks the last byte caused by an input beat,
// tuser marks the second checksum byte that closes a frame.
// A start beat gives 6 output bytes (8 for length zero, checksum included);
// a payload beat gives 1 byte, or 3 on the last byte of the frame. A payload
// beat outside a frame is taken and dropped. A start beat abandons an open
// frame without checksum.
// The first output byte of a beat is valid the cycle after it is accepted.
// One input beat is taken per cycle while each gives one byte and the
// receiver takes it; a burst of N bytes holds s_tready low until its last
// byte is taken, since m_tdata carries one byte per output beat.
// Reset clears the checksum, frame state and any pending burst. When the
// receiver stalls, the current byte holds and input stops while any byte of
// the burst is pending.
`include "assert_macros.svh"

module ubx_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cls_byte[7:0], msg_id[15:8], payload_len[31:16], data_byte[39:32]
	input  logic [ubxe_pkg::IN_DATA_W-1:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	// run_last
	output logic        m_tlast,
	// frame_end[0]
	output logic        m_tuser
);
	import ubxe_pkg::*;

	frame_state_t st_q, st_nxt;
	burst_t       burst;
	byte_t [BURST_MAX-1:0] byte_q;
	cnt_t         cnt_q;
	logic         cks_q;
	logic         s_take, m_take, last_beat;

	ubxe_build u_build (
		.kind        (s_tuser),
		.cls_byte    (s_tdata[7:0]),
		.msg_id      (s_tdata[15:8]),
		.payload_len (s_tdata[31:16]),
		.data_byte   (s_tdata[39:32]),
		.st          (st_q),
		.st_nxt      (st_nxt),
		.burst       (burst)
	);

	assign last_beat = (cnt_q == cnt_t'(1));
	assign m_tvalid  = (cnt_q != '0);
	assign m_take    = m_tvalid && m_tready;
	assign s_tready  = (cnt_q == '0) || (last_beat && m_tready);
	assign s_take    = s_tvalid && s_tready;
	assign m_tdata   = byte_q[0];
	assign m_tlast   = last_beat;
	assign m_tuser   = last_beat && cks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= '0;
			cks_q <= 1'b0;
		end else if (s_take) begin
			st_q  <= st_nxt;
			cnt_q <= burst.cnt;
			cks_q <= burst.cks;
		end else if (m_take) begin
			cnt_q <= cnt_q - cnt_t'(1);
		end
	end

	// advance the burst one byte per output beat
	always_ff @(posedge clk) begin
		if (s_take) begin
			byte_q <= burst.bytes;
		end else if (m_take) begin
			for (int i = 0; i < BURST_MAX - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
			end
		end
	end

	`ASSERT_IMPL(a_end_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`ASSERT_IMPL(a_no_take_midburst, clk, arst_n, m_tvalid && !m_tlast, !s_tready)
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= cnt_t'(BURST_MAX))
	`ASSERT_NEXT(a_start_fills, clk, arst_n, s_take && s_tuser == KIND_START,
		m_tvalid && m_tdata == SYNC_FIRST)

endmodule

>>> rtl/core/ubxe_build.sv
// Frame builder: turns one input beat into its output burst and next state.
module ubxe_build (
	input  logic                 kind,
	input  ubxe_pkg::byte_t      cls_byte,
	input  ubxe_pkg::byte_t      msg_id,
	input  logic [15:0]          payload_len,
	input  ubxe_pkg::byte_t      data_byte,
	input  ubxe_pkg::frame_state_t st,
	output ubxe_pkg::frame_state_t st_nxt,
	output ubxe_pkg::burst_t     burst
);
	import ubxe_pkg::*;

	always_comb begin
		byte_t       a1, a2, a3, a4;
		byte_t       b1, b2, b3, b4;
		logic [15:0] left_dec;
		st_nxt = st;
		burst.bytes = '0;
		burst.cnt = '0;
		burst.cks = 1'b0;
		a1 = cls_byte;
		b1 = cls_byte;
		a2 = a1 + msg_id;
		b2 = b1 + a2;
		a3 = a2 + payload_len[7:0];
		b3 = b2 + a3;
		a4 = a3 + payload_len[15:8];
		b4 = b3 + a4;
		left_dec = st.bytes_left - 16'd1;
		if (kind == KIND_START) begin
			burst.bytes[0] = SYNC_FIRST;
			burst.bytes[1] = SYNC_SECOND;
			burst.bytes[2] = cls_byte;
			burst.bytes[3] = msg_id;
			burst.bytes[4] = payload_len[7:0];
			burst.bytes[5] = payload_len[15:8];
			st_nxt.sum_a = a4;
			st_nxt.sum_b = b4;
			st_nxt.bytes_left = payload_len;
			if (payload_len == 16'd0) begin
				burst.bytes[6] = a4;
				burst.bytes[7] = b4;
				burst.cnt = cnt_t'(8);
				burst.cks = 1'b1;
				st_nxt.in_frame = 1'b0;
			end else begin
				burst.cnt = cnt_t'(6);
				st_nxt.in_frame = 1'b1;
			end
		end else if (st.in_frame) begin
			// fold payload byte and pass it through
			st_nxt.sum_a = st.sum_a + data_byte;
			st_nxt.sum_b = st.sum_b + st_nxt.sum_a;
			st_nxt.bytes_left = left_dec;
			burst.bytes[0] = data_byte;
			if (left_dec == 16'd0) begin
				burst.bytes[1] = st_nxt.sum_a;
				burst.bytes[2] = st_nxt.sum_b;
				burst.cnt = cnt_t'(3);
				burst.cks = 1'b1;
				st_nxt.in_frame = 1'b0;
			end else begin
				burst.cnt = cnt_t'(1);
			end
		end
	end

endmodule
